// ----- rtl/mpps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mpps_pkg;

  localparam int FRAC_BITS = 24;
  localparam int WORD_BITS = 32;

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t WORD_MAX  = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN  = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam word_t PHASE_ONE = word_t'(64'(1) << FRAC_BITS);

  typedef logic [2:0] status_t;
  localparam status_t STATUS_OK          = 3'd0;
  localparam status_t STATUS_NOT_STARTED = 3'd1;
  localparam status_t STATUS_BAD_DT      = 3'd2;
  localparam status_t STATUS_BAD_TAU     = 3'd3;
  localparam status_t STATUS_PHASE_NEG   = 3'd4;

  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t CFG_SYSTEM_ORDER = 2'd0;
  localparam cfg_index_t CFG_DECAY_ALPHA  = 2'd1;
  localparam cfg_index_t CFG_DAMPING_BETA = 2'd2;

  localparam logic [1:0]  ORDER_SECOND        = 2'd2;
  localparam logic [1:0]  SYSTEM_ORDER_RESET  = 2'd2;
  localparam logic [30:0] DECAY_ALPHA_RESET   = 31'd419430400;
  localparam logic [30:0] DAMPING_BETA_RESET  = 31'd104857600;

  typedef struct packed {
    logic               operation;
    logic        [24:0] time_step;
    logic signed [31:0] tau_relative;
    logic signed [31:0] coupling_term;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] phase_position;
    logic signed [31:0] phase_velocity;
    logic signed [31:0] phase_accel;
    logic signed [31:0] gating_multiplier;
    status_t            status;
  } out_item_t;

  function automatic word_t sat_add(input word_t a, input word_t b);
    logic signed [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    end
    return s[WORD_BITS-1:0];
  endfunction

  function automatic word_t sat_neg(input word_t a);
    if (a == WORD_MIN) begin
      return WORD_MAX;
    end
    return -a;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/movement_primitive_phase_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Start items and rejected steps go from idle straight to the done state, which presents the result.
// A second-order step runs three divides and four multiplies, a first-order step two and three: each divide runs
// on a shared restoring divider at one quotient bit per cycle (or is skipped when it saturates),
// each multiply runs on one shared 32x32 multiplier with a registered product.
// Throughput: one item at a time; the next item is taken once the sequencer is back in idle.
// Reset (synchronous, rst high): registers to defaults, phase 1.0, derivatives 0, not started.
module movement_primitive_phase_step (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire mpps_pkg::in_item_t     in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output mpps_pkg::out_item_t         out_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire mpps_pkg::cfg_index_t   cfg_index,
  input  wire logic [31:0]            cfg_data
);

  localparam int W     = mpps_pkg::WORD_BITS;
  localparam int F     = mpps_pkg::FRAC_BITS;
  localparam int IW    = W - F;
  localparam int SH_W  = 2 * W - F;
  localparam int CNT_W = $clog2(W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_MSAT  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [2:0] ST_XDD = 3'd0;
  localparam logic [2:0] ST_BX  = 3'd1;
  localparam logic [2:0] ST_AT  = 3'd2;
  localparam logic [2:0] ST_VD  = 3'd3;
  localparam logic [2:0] ST_XD  = 3'd4;
  localparam logic [2:0] ST_XUP = 3'd5;
  localparam logic [2:0] ST_VUP = 3'd6;

  function automatic logic [W-1:0] mag(input mpps_pkg::word_t a);
    return a[W-1] ? W'(-a) : W'(a);
  endfunction

  logic [2:0]       state;
  logic [2:0]       step;
  logic [2:0]       step_next;

  logic [1:0]       system_order;
  logic [30:0]      decay_alpha;
  logic [30:0]      damping_beta;

  logic             started;
  mpps_pkg::word_t  phase_x;
  mpps_pkg::word_t  aux_v;
  mpps_pkg::word_t  aux_vd;
  mpps_pkg::word_t  phase_xd;
  mpps_pkg::word_t  phase_xdd;
  mpps_pkg::word_t  acc;

  logic [24:0]      dt_reg;
  mpps_pkg::word_t  tau_reg;
  mpps_pkg::word_t  cpl_reg;
  mpps_pkg::status_t status_reg;

  logic [2*W-1:0]   mul_prod;
  logic             op_neg;
  logic [W-1:0]     div_rem;
  logic [W-1:0]     div_bits;
  logic [W-1:0]     div_quo;
  logic [CNT_W-1:0] div_cnt;

  logic             second;
  logic             is_div;
  mpps_pkg::word_t  mul_a;
  mpps_pkg::word_t  mul_b;
  mpps_pkg::word_t  addend;
  mpps_pkg::word_t  div_a;
  logic [W-1:0]     divisor;
  logic [W-1:0]     div_m;
  logic             div_big;
  logic [W:0]       div_r2;
  logic             div_ge;
  logic [W-1:0]     div_q_next;
  logic [SH_W-1:0]  shifted;
  mpps_pkg::word_t  qmul_val;
  mpps_pkg::word_t  res_val;
  logic             res_en;
  logic             in_fire;
  logic             out_free;

  assign second    = (system_order == mpps_pkg::ORDER_SECOND);
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign divisor   = W'(tau_reg);
  assign is_div    = (step == ST_XDD) || (step == ST_VD) || (step == ST_XD);

  always_comb begin
    unique case (step)
      ST_XDD:  step_next = second ? ST_BX : ST_AT;
      ST_BX:   step_next = ST_AT;
      ST_AT:   step_next = second ? ST_VD : ST_XD;
      ST_VD:   step_next = ST_XD;
      ST_XD:   step_next = ST_XUP;
      ST_XUP:  step_next = ST_VUP;
      default: step_next = ST_VUP;
    endcase
  end

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    addend = '0;
    div_a  = '0;
    unique case (step)
      ST_XDD: div_a = aux_vd;
      ST_BX: begin
        mul_a  = mpps_pkg::word_t'(damping_beta);
        mul_b  = mpps_pkg::sat_neg(phase_x);
        addend = mpps_pkg::sat_neg(aux_v);
      end
      ST_AT: begin
        mul_a  = mpps_pkg::word_t'(decay_alpha);
        mul_b  = acc;
        addend = cpl_reg;
      end
      ST_VD: div_a = acc;
      ST_XD: div_a = second ? aux_v : acc;
      ST_XUP: begin
        mul_a  = phase_xd;
        mul_b  = mpps_pkg::word_t'(dt_reg);
        addend = phase_x;
      end
      ST_VUP: begin
        mul_a  = aux_vd;
        mul_b  = mpps_pkg::word_t'(dt_reg);
        addend = aux_v;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_comb begin
    div_m      = mag(div_a);
    div_big    = {{IW{1'b0}}, div_m} >= {divisor, {IW{1'b0}}};
    div_r2     = {div_rem, div_bits[W-1]};
    div_ge     = div_r2 >= {1'b0, divisor};
    div_q_next = {div_quo[W-2:0], div_ge};

    shifted = mul_prod[2*W-1:F];
    if (!op_neg) begin
      qmul_val = (|shifted[SH_W-1:W-1]) ? mpps_pkg::WORD_MAX
                                        : mpps_pkg::word_t'(shifted[W-1:0]);
    end else if ((|shifted[SH_W-1:W]) || (shifted[W-1] && (|shifted[W-2:0]))) begin
      qmul_val = mpps_pkg::WORD_MIN;
    end else begin
      qmul_val = mpps_pkg::word_t'(-shifted[W-1:0]);
    end

    res_en  = 1'b0;
    res_val = '0;
    priority if (state == S_ISSUE && is_div && div_big) begin
      res_en  = 1'b1;
      res_val = div_a[W-1] ? mpps_pkg::WORD_MIN : mpps_pkg::WORD_MAX;
    end else if (state == S_DIV && div_cnt == '0) begin
      res_en = 1'b1;
      if (!op_neg) begin
        res_val = div_q_next[W-1] ? mpps_pkg::WORD_MAX : mpps_pkg::word_t'(div_q_next);
      end else begin
        res_val = (div_q_next[W-1] && (|div_q_next[W-2:0])) ? mpps_pkg::WORD_MIN
                                                            : mpps_pkg::word_t'(-div_q_next);
      end
    end else if (state == S_MSAT) begin
      res_en  = 1'b1;
      res_val = mpps_pkg::sat_add(qmul_val, addend);
    end else begin
      res_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= ST_XDD;
      out_valid    <= 1'b0;
      system_order <= mpps_pkg::SYSTEM_ORDER_RESET;
      decay_alpha  <= mpps_pkg::DECAY_ALPHA_RESET;
      damping_beta <= mpps_pkg::DAMPING_BETA_RESET;
      started      <= 1'b0;
      phase_x      <= mpps_pkg::PHASE_ONE;
      aux_v        <= '0;
      aux_vd       <= '0;
      phase_xd     <= '0;
      phase_xdd    <= '0;
      status_reg   <= mpps_pkg::STATUS_OK;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          mpps_pkg::CFG_SYSTEM_ORDER: system_order <= cfg_data[1:0];
          mpps_pkg::CFG_DECAY_ALPHA:  decay_alpha  <= cfg_data[30:0];
          mpps_pkg::CFG_DAMPING_BETA: damping_beta <= cfg_data[30:0];
          default: begin
          end
        endcase
      end

      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            dt_reg  <= in_data.time_step;
            tau_reg <= in_data.tau_relative;
            cpl_reg <= in_data.coupling_term;
            acc     <= mpps_pkg::sat_neg(phase_x);
            step    <= ST_XDD;
            priority if (in_data.operation == mpps_pkg::OP_START) begin
              phase_x    <= mpps_pkg::PHASE_ONE;
              aux_v      <= '0;
              aux_vd     <= '0;
              phase_xd   <= '0;
              phase_xdd  <= '0;
              started    <= 1'b1;
              status_reg <= mpps_pkg::STATUS_OK;
              state      <= S_DONE;
            end else if (!started) begin
              status_reg <= mpps_pkg::STATUS_NOT_STARTED;
              state      <= S_DONE;
            end else if (in_data.time_step == '0) begin
              status_reg <= mpps_pkg::STATUS_BAD_DT;
              state      <= S_DONE;
            end else if (in_data.tau_relative[31] || in_data.tau_relative == '0) begin
              status_reg <= mpps_pkg::STATUS_BAD_TAU;
              state      <= S_DONE;
            end else begin
              status_reg <= mpps_pkg::STATUS_OK;
              state      <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          if (is_div) begin
            op_neg   <= div_a[W-1];
            div_rem  <= W'(div_m >> IW);
            div_bits <= {div_m[IW-1:0], {F{1'b0}}};
            div_quo  <= '0;
            div_cnt  <= CNT_LAST;
            if (!div_big) begin
              state <= S_DIV;
            end
          end else begin
            op_neg   <= mul_a[W-1] ^ mul_b[W-1];
            mul_prod <= (2*W)'(mag(mul_a)) * (2*W)'(mag(mul_b));
            state    <= S_MSAT;
          end
        end
        S_DIV: begin
          div_rem  <= div_ge ? W'(div_r2 - {1'b0, divisor}) : div_r2[W-1:0];
          div_bits <= {div_bits[W-2:0], 1'b0};
          div_quo  <= div_q_next;
          div_cnt  <= div_cnt - 1'b1;
        end
        S_MSAT: begin
        end
        S_DONE: begin
          if (out_free) begin
            out_valid                  <= 1'b1;
            out_data.phase_position    <= phase_x;
            out_data.phase_velocity    <= phase_xd;
            out_data.phase_accel       <= phase_xdd;
            out_data.gating_multiplier <= second ? aux_v : phase_x;
            out_data.status            <= (status_reg == mpps_pkg::STATUS_OK && phase_x[W-1])
                                          ? mpps_pkg::STATUS_PHASE_NEG : status_reg;
            state                      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (res_en) begin
        unique case (step)
          ST_XDD: phase_xdd <= res_val;
          ST_BX:  acc <= res_val;
          ST_AT: begin
            acc <= res_val;
            if (!second) begin
              aux_vd <= '0;
            end
          end
          ST_VD:  aux_vd <= res_val;
          ST_XD:  phase_xd <= res_val;
          ST_XUP: phase_x <= res_val;
          default: aux_v <= res_val;
        endcase
        step  <= step_next;
        state <= (step == ST_VUP) ? S_DONE : S_ISSUE;
      end
    end
  end

  a_start_fresh: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_data.operation == mpps_pkg::OP_START)
      |=> (phase_x == mpps_pkg::PHASE_ONE && aux_v == '0 && state == S_DONE))
    else $error("start item did not reset the phase state");

  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_data.operation == mpps_pkg::OP_STEP && !started)
      |=> ($stable(phase_x) && $stable(aux_v) && status_reg == mpps_pkg::STATUS_NOT_STARTED))
    else $error("step before start changed the state");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_rem < divisor))
    else $error("divider remainder not below divisor");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised outside the done state");

endmodule

`default_nettype wire
